/* sv/drsf_pkg.sv */
// Package for the two-reader broadcast FIFO.
// Holds action and status codes and the result record; no dependencies.
package drsf_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_DONE   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic    rd_ok;
    status_e status;
    logic    done;
  } result_t;

endpackage

/* sv/dual_reader_shared_fifo_unit.sv */
// Top level of the two-reader broadcast FIFO: control, store and result register.
// Uses drsf_pkg, drsf_ctrl and drsf_ram.
//
//  channel | valid      | ready      | payload
//  --------+------------+------------+-----------------------------------
//  in      | in_valid_i | in_ready_o | action_i, reader_i, data_in_i
//  out     | out_valid_o| out_ready_i| status_o, data_out_o, writing_done_o
//
// One transaction per cycle unless the output stalls; each result appears in the
// cycle after its transaction, the read word from the store's registered read port.
// The result register frees in the cycle it is taken, so input flows on.
// A stalled output holds the result register and blocks the input.
// Reset clears the pointers and the done flag; no clearing pass is needed.
module dual_reader_shared_fifo_unit import drsf_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        reader_i,
  input  logic [63:0] data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] data_out_o,
  output logic        writing_done_o
);

  localparam int AW = $clog2(DEPTH);

  logic                  accept;
  logic                  out_valid_q, out_valid_d;
  result_t               res_d, res_q;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  drsf_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .reader_i    (reader_i),
    .data_i      (data_in_i[DATA_WIDTH-1:0]),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .res_o       (res_d)
  );

  drsf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign writing_done_o = res_q.done;
  assign data_out_o     = res_q.rd_ok ? 64'(ram_rdata) : 64'd0;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transaction lost its result");

  a_read_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.rd_ok) |-> (res_q.status == ST_OK))
    else $error("read word flagged with failure status");

  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !accept)
    else $error("transaction taken over a stalled result");

endmodule

/* sv/drsf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/drsf_ctrl.sv */
// Pointer and flag control for the two-reader broadcast FIFO.
// Decides each transaction, drives the store's ports; uses drsf_pkg.
module drsf_ctrl import drsf_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [1:0]               action_i,
  input  logic                     reader_i,
  input  logic [DATA_WIDTH-1:0]    data_i,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [DATA_WIDTH-1:0]    ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  output result_t                  res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(2 * DEPTH);
  localparam logic [PW-1:0] PtrMax   = PW'(2 * DEPTH - 1);
  localparam logic [PW-1:0] DepthPtr = PW'(DEPTH);
  localparam logic [PW:0]   TwoDepth = (PW + 1)'(2 * DEPTH);
  localparam logic [PW:0]   DepthLag = (PW + 1)'(DEPTH);

  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] rp_q [2];
  logic [PW-1:0] rp_d [2];
  logic          done_q, done_d;
  logic [PW:0]   lag [2];
  logic [PW-1:0] rp_sel;
  logic          full;
  logic          caught_up;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PtrMax) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_addr(input logic [PW-1:0] p);
    logic [PW-1:0] a;
    a = (p >= DepthPtr) ? p - DepthPtr : p;
    return a[AW-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lag[i] = {1'b0, wp_q} + ((wp_q >= rp_q[i]) ? '0 : TwoDepth) - {1'b0, rp_q[i]};
    end
  end

  assign full      = (lag[0] >= DepthLag) || (lag[1] >= DepthLag);
  assign rp_sel    = rp_q[reader_i];
  assign caught_up = (rp_sel == wp_q);

  always_comb begin
    wp_d        = wp_q;
    rp_d[0]     = rp_q[0];
    rp_d[1]     = rp_q[1];
    done_d      = done_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    res_o.rd_ok = 1'b0;
    res_o.status = ST_OK;
    case (action_i)
      ACT_INSERT: begin
        if (full) begin
          res_o.status = ST_FULL;
        end else begin
          ram_we_o = accept_i;
          if (accept_i) begin
            wp_d = ptr_inc(wp_q);
          end
        end
      end
      ACT_READ: begin
        if (caught_up) begin
          res_o.status = ST_NO_DATA;
        end else begin
          res_o.rd_ok = 1'b1;
          ram_re_o    = accept_i;
          if (accept_i) begin
            rp_d[reader_i] = ptr_inc(rp_sel);
          end
        end
      end
      ACT_DONE: begin
        if (accept_i) begin
          done_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_o.done = (action_i == ACT_DONE) ? 1'b1 : done_q;
  end

  assign ram_waddr_o = ptr_addr(wp_q);
  assign ram_wdata_o = data_i;
  assign ram_raddr_o = ptr_addr(rp_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q[0] <= '0;
      rp_q[1] <= '0;
      done_q  <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      rp_q[0] <= rp_d[0];
      rp_q[1] <= rp_d[1];
      done_q  <= done_d;
    end
  end

  a_lag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lag[0] <= DepthLag) && (lag[1] <= DepthLag))
    else $error("reader lag exceeds depth");

  a_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("store written and read by one transaction");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("done flag cleared");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for dual_reader_shared_fifo_unit, the two-reader broadcast FIFO.
// Predicts each result from a local copy of store, pointers and done flag; needs drsf_pkg.
// Directed cases first, then random traffic with idling, then a long output stall.
module testbench import drsf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FIFO_DEPTH  = 16;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;

  typedef struct {
    status_e     status;
    logic [63:0] data;
    logic        done;
  } outcome_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  action       = ACT_INSERT;
  logic        reader       = 1'b0;
  logic [63:0] data_in      = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [1:0]  status;
  logic [63:0] data_out;
  logic        writing_done;

  logic [63:0] shadow_store [FIFO_DEPTH];
  logic [4:0]  shadow_wr_ptr;
  logic [4:0]  shadow_rd_ptr [2];
  logic        shadow_done;
  outcome_t    expected_results [$];

  int tx_max_gap   = 0;
  int rx_max_stall = 0;
  int hold_request = 0;
  int errors       = 0;
  int cycle_count  = 0;
  int n_inserted   = 0;
  int n_full       = 0;
  int n_delivered  = 0;
  int n_no_data    = 0;
  int n_checked    = 0;

  dual_reader_shared_fifo_unit #(
    .DEPTH     (FIFO_DEPTH),
    .DATA_WIDTH(64)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .reader_i      (reader),
    .data_in_i     (data_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .data_out_o    (data_out),
    .writing_done_o(writing_done)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic void fifo_predict(logic [1:0] act, logic who, logic [63:0] word);
    outcome_t   res;
    logic [4:0] lag0;
    logic [4:0] lag1;
    res.status = ST_OK;
    res.data   = '0;
    case (act)
      ACT_INSERT: begin
        lag0 = shadow_wr_ptr - shadow_rd_ptr[0];
        lag1 = shadow_wr_ptr - shadow_rd_ptr[1];
        if (lag0 >= FIFO_DEPTH || lag1 >= FIFO_DEPTH) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          shadow_store[shadow_wr_ptr[3:0]] = word;
          shadow_wr_ptr = shadow_wr_ptr + 5'd1;
          n_inserted++;
        end
      end
      ACT_READ: begin
        if (shadow_rd_ptr[who] == shadow_wr_ptr) begin
          res.status = ST_NO_DATA;
          n_no_data++;
        end else begin
          res.data = shadow_store[shadow_rd_ptr[who][3:0]];
          shadow_rd_ptr[who] = shadow_rd_ptr[who] + 5'd1;
          n_delivered++;
        end
      end
      ACT_DONE: shadow_done = 1'b1;
      default: ;
    endcase
    res.done = shadow_done;
    expected_results.push_back(res);
  endfunction

  task automatic send_item(logic [1:0] act, logic who, logic [63:0] word);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    action   <= act;
    reader   <= who;
    data_in  <= word;
    do @(posedge clk); while (!in_ready);
    fifo_predict(act, who, word);
  endtask

  task automatic check_result();
    outcome_t exp;
    n_checked++;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result status=%0d data=%h done=%b", $realtime, status,
               data_out, writing_done);
      errors++;
      return;
    end
    exp = expected_results.pop_front();
    if (status !== exp.status) begin
      $display("%0t: status expected %0d actual %0d", $realtime, exp.status, status);
      errors++;
    end
    if (data_out !== exp.data) begin
      $display("%0t: data_out expected %h actual %h", $realtime, exp.data, data_out);
      errors++;
    end
    if (writing_done !== exp.done) begin
      $display("%0t: writing_done expected %b actual %b", $realtime, exp.done,
               writing_done);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
  end

  initial begin
    int  stall_left;
    int  hold_left;
    logic took;
    stall_left = 0;
    hold_left  = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      took = out_valid && out_ready;
      @(negedge clk);
      if (took) stall_left = $urandom_range(0, rx_max_stall);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_empty_reads();
    send_item(ACT_READ, 1'b0, random_word());
    send_item(ACT_READ, 1'b1, random_word());
    send_item(ACT_UNUSED, 1'b1, random_word());
  endtask

  task automatic test_fill_to_full();
    logic [63:0] extremes [6];
    extremes = '{64'h0, {64{1'b1}}, {32{2'b10}}, {32{2'b01}}, 64'h1, 64'h8000_0000_0000_0000};
    foreach (extremes[i]) send_item(ACT_INSERT, 1'b0, extremes[i]);
    repeat (FIFO_DEPTH - 6) send_item(ACT_INSERT, 1'b0, random_word());
    send_item(ACT_INSERT, 1'b0, random_word());
    send_item(ACT_READ, 1'b0, random_word());
    send_item(ACT_INSERT, 1'b1, random_word());
    send_item(ACT_READ, 1'b1, random_word());
    send_item(ACT_INSERT, 1'b0, {64{1'b1}});
  endtask

  task automatic test_done_flag();
    send_item(ACT_DONE, 1'b0, random_word());
    send_item(ACT_DONE, 1'b1, random_word());
    send_item(ACT_INSERT, 1'b0, random_word());
    send_item(ACT_READ, 1'b1, random_word());
  endtask

  task automatic test_random_traffic(int phases, int items_per_phase);
    int          ins_pct;
    int          r0_pct;
    int          roll;
    logic [1:0]  act;
    logic        who;
    for (int p = 0; p < phases; p++) begin
      tx_max_gap   = (p % 4 == 1 || p % 4 == 2) ? 7 : 0;
      rx_max_stall = (p % 4 == 1 || p % 4 == 3) ? 7 : 0;
      ins_pct      = (p % 3 == 0) ? 50 : ((p % 3 == 1) ? 75 : 25);
      r0_pct       = (p % 5 < 2) ? 50 : ((p % 5 < 4) ? 85 : 15);
      repeat (items_per_phase) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) act = ACT_UNUSED;
        else if (roll < 4) act = ACT_DONE;
        else if (roll < 4 + ins_pct) act = ACT_INSERT;
        else act = ACT_READ;
        who = ($urandom_range(0, 99) < r0_pct) ? 1'b0 : 1'b1;
        send_item(act, who, random_word());
      end
    end
  endtask

  task automatic test_output_backpressure();
    tx_max_gap   = 0;
    rx_max_stall = 0;
    hold_request = 80;
    for (int i = 0; i < 40; i++) begin
      send_item((i % 2 == 0) ? ACT_INSERT : ACT_READ, i[1], random_word());
    end
  endtask

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
    shadow_wr_ptr    = '0;
    shadow_rd_ptr[0] = '0;
    shadow_rd_ptr[1] = '0;
    shadow_done      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_reads();
    test_fill_to_full();
    test_done_flag();
    test_random_traffic(8, 110);
    test_output_backpressure();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d results: %0d inserts, %0d full rejects, %0d reads delivered",
             n_checked, n_inserted, n_full, n_delivered);
    $display("%0d reads found nothing; idle, stall and long output hold phases run",
             n_no_data);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
